### design/lcas_pkg.sv
// ----------------------------------------------------------------------------
// lcas_pkg
// Shared types, constants and helper functions for the life step core.
// ----------------------------------------------------------------------------
package lcas_pkg;

	localparam int COLS_REG_W = 11;
	localparam int ROWS_W     = 13;
	localparam int CFG_W      = 13;
	localparam int COUNT_W    = 4;

	localparam logic [COLS_REG_W-1:0] COLS_RESET  = 11'd800;
	localparam logic [ROWS_W-1:0]     ROWS_RESET  = 13'd400;
	localparam logic [ROWS_W-1:0]     ROWS_LIMIT  = 13'd4096;
	localparam int                    MIN_COLUMNS = 3;

	localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
	localparam logic [COUNT_W-1:0] KEEP_COUNT  = 4'd2;

	// register indexes on the config port
	localparam logic CFG_GRID_COLUMNS = 1'b0;
	localparam logic CFG_GRID_ROWS    = 1'b1;

	// per-item control computed from the frame position
	typedef struct packed {
		logic state_in;   // value of the new cell, forced dead outside the grid or when the opcode is set
		logic emit;       // item yields a result
		logic wrap;       // column 0: result for last cell two rows up
		logic mask_top;
		logic mask_bot;
		logic mask_left;
		logic last;
	} cell_info_t;

	// shift each window row one column older and insert the new column
	function automatic logic [8:0] win_push(logic [8:0] w, logic top, logic mid,
		logic bot);
		logic [8:0] o;
		o[2:0] = {top, w[2], w[1]};
		o[5:3] = {mid, w[5], w[4]};
		o[8:6] = {bot, w[8], w[7]};
		return o;
	endfunction

	// live neighbors of the centre of a 3x3 neighborhood, edges masked
	function automatic logic [COUNT_W-1:0] count_live(logic [8:0] nb, logic mask_top,
		logic mask_bot, logic mask_left);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if (!(rr == 0 && mask_top) && !(rr == 2 && mask_bot) &&
					!(cc == 0 && mask_left) && !(rr == 1 && cc == 1)) begin
					n = n + {{(COUNT_W-1){1'b0}}, nb[3*rr+cc]};
				end
			end
		end
		return n;
	endfunction

endpackage

### design/lcas_line_store.sv
// ----------------------------------------------------------------------------
// lcas_line_store
// Two line stores kept as one two-bit wide memory, registered read with
// bypass of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
module lcas_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,   // {upper, lower}
	output logic [1:0]    rd_data    // {upper, lower}
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

### design/lcas_position.sv
// ----------------------------------------------------------------------------
// lcas_position
// Frame position counters and the per-item edge and result flags.
// ----------------------------------------------------------------------------
module lcas_position #(
	parameter int MAX_COLUMNS = 1024,
	parameter int CW          = $clog2(MAX_COLUMNS),
	parameter int UW          = $clog2(MAX_COLUMNS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic                      advance,
	input  logic [UW-1:0]             cols_used,
	input  logic [lcas_pkg::ROWS_W-1:0] rows_used,
	input  logic                      opcode,
	input  logic                      alive,
	output logic [CW-1:0]             col,
	output lcas_pkg::cell_info_t      info
);
	import lcas_pkg::*;

	logic [CW-1:0]     col_q;
	logic [ROWS_W-1:0] row_q;
	logic [UW:0]       col_inc;
	logic [ROWS_W:0]   rows_p1;
	logic [ROWS_W:0]   row_ext;
	logic              past_end;

	assign col_inc  = {1'b0, UW'(col_q)} + 1'b1;
	assign rows_p1  = {1'b0, rows_used} + 1'b1;
	assign row_ext  = {1'b0, row_q};
	assign past_end = row_ext >= rows_p1;

	always_comb begin
		info.wrap      = (col_q == '0);
		info.state_in  = !opcode && (row_q < rows_used) && alive;
		info.emit      = info.wrap ? (row_q >= ROWS_W'(2)) : (row_q >= ROWS_W'(1));
		info.mask_top  = info.wrap ? (row_q == ROWS_W'(2)) : (row_q == ROWS_W'(1));
		info.mask_bot  = info.wrap ? past_end : (row_q >= rows_used);
		info.mask_left = !info.wrap && (col_q == CW'(1));
		info.last      = info.wrap && (row_ext == rows_p1);
	end

	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (info.wrap && past_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= {1'b0, cols_used}) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

endmodule

### design/lcas_eval.sv
// ----------------------------------------------------------------------------
// lcas_eval
// 3x3 window update, neighbor count and the B3/S23 rule, with the result
// register on the output stream.
// ----------------------------------------------------------------------------
module lcas_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s1_valid,
	input  lcas_pkg::cell_info_t s1_info,
	input  logic [1:0]           store_data,  // {upper, lower}
	output logic                 s1_adv,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,     // next_alive, neighbor_count[3:0], zero pad
	output logic                 m_tlast      // last_of_frame
);
	import lcas_pkg::*;

	logic [8:0]         win_q;
	logic [8:0]         post;
	logic [8:0]         nb;
	logic [COUNT_W-1:0] n;
	logic               next;
	logic               m_valid_q;
	logic               next_q;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;

	assign post = win_push(win_q, store_data[1], store_data[0], s1_info.state_in);

	always_comb begin
		if (s1_info.wrap) begin
			// window before the new column, centre one column older
			nb = {1'b0, win_q[8:7], 1'b0, win_q[5:4], 1'b0, win_q[2:1]};
		end else begin
			nb = post;
		end
	end

	assign n    = count_live(nb, s1_info.mask_top, s1_info.mask_bot, s1_info.mask_left);
	assign next = (n == BIRTH_COUNT) || (nb[4] && n == KEEP_COUNT);

	assign s1_adv = s1_valid && (!s1_info.emit || !m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				win_q <= post;
			end
			if (s1_adv && s1_info.emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_info.emit) begin
			next_q  <= next;
			count_q <= n;
			last_q  <= s1_info.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, count_q, next_q};
	assign m_tlast  = last_q;

endmodule

### design/life_cellular_automaton_step_core.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_core
// One generation of B3/S23 Life over a bounded grid streamed in raster order.
// ----------------------------------------------------------------------------
// an accepted item is held in the stage 1 register, its result then in the output register
// throughput: one item per cycle unless the output stalls, bounded by the line
//   store read-modify-write (registered read, write as stage 1 advances, same-column bypass)
// reset clears positions, window and valid flags; config restores 800 x 400
// the line store is not cleared: its contents never reach a result unwritten
module life_cellular_automaton_step_core #(
	parameter int MAX_COLUMNS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // alive, zero pad
	input  logic                       s_tuser,   // opcode
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // next_alive, neighbor_count[3:0], zero pad
	output logic                       m_tlast,   // last_of_frame
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lcas_pkg::CFG_W-1:0] cfg_data
);
	import lcas_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int UW = $clog2(MAX_COLUMNS + 1);

	logic [COLS_REG_W-1:0] grid_columns_q;
	logic [ROWS_W-1:0]     grid_rows_q;
	logic [UW-1:0]         cols_used;
	logic [ROWS_W-1:0]     rows_used;

	logic       accept;
	logic       s1_adv;
	logic       s1_valid_q;
	cell_info_t info;
	cell_info_t info_s1;
	logic [CW-1:0] col;
	logic [CW-1:0] col_s1;
	logic [1:0]    store_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= COLS_RESET;
			grid_rows_q    <= ROWS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_data[COLS_REG_W-1:0];
				CFG_GRID_ROWS:    grid_rows_q    <= cfg_data[ROWS_W-1:0];
				default:          grid_rows_q    <= grid_rows_q;
			endcase
		end
	end

	always_comb begin
		if (int'(grid_columns_q) < MIN_COLUMNS) begin
			cols_used = UW'(MIN_COLUMNS);
		end else if (int'(grid_columns_q) > MAX_COLUMNS) begin
			cols_used = UW'(MAX_COLUMNS);
		end else begin
			cols_used = UW'(grid_columns_q);
		end
		if (grid_rows_q == '0) begin
			rows_used = ROWS_W'(1);
		end else if (grid_rows_q > ROWS_LIMIT) begin
			rows_used = ROWS_LIMIT;
		end else begin
			rows_used = grid_rows_q;
		end
	end

	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;

	lcas_position #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.advance   (accept),
		.cols_used (cols_used),
		.rows_used (rows_used),
		.opcode    (s_tuser),
		.alive     (s_tdata[0]),
		.col       (col),
		.info      (info)
	);

	lcas_line_store #(
		.DEPTH(MAX_COLUMNS)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data ({store_data[0], info_s1.state_in}),
		.rd_data (store_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			col_s1  <= col;
		end
	end

	lcas_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid_q),
		.s1_info    (info_s1),
		.store_data (store_data),
		.s1_adv     (s1_adv),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

### design/lcas_checker.sv
// ----------------------------------------------------------------------------
// lcas_checker
// Port-level checks on the result stream of the life step core.
// ----------------------------------------------------------------------------
module lcas_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:1] <= 4'd8 && m_tdata[7:5] == 3'b000)
		else $error("neighbor count out of range");

	// alive next generation only with two or three neighbors
	a_rule_alive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[4:1] == 4'd2 || m_tdata[4:1] == 4'd3)
		else $error("live result with wrong count");

	a_rule_birth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:1] == 4'd3 |-> m_tdata[0])
		else $error("three neighbors but dead result");

endmodule

bind life_cellular_automaton_step_core lcas_checker u_lcas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
